// ===== hw/rtl/dwpi_pkg.sv =====
// Shared types and constants for the dual-wheel PI speed loop.
`timescale 1ns / 1ps
`default_nettype none
package dwpi_pkg;

  // Field widths
  localparam int CNT_W   = 32;
  localparam int TGT_W   = 11;
  localparam int GAIN_W  = 18;
  localparam int DUTY_W  = 10;
  localparam int SPD_W   = 24;
  localparam int INT_W   = 40;

  // Loop constants
  localparam int FILTER_TAPS = 3;
  localparam int HIST_DEPTH  = FILTER_TAPS - 1;
  localparam int PWM_TOP     = 800;
  localparam int DIFF_W      = 16;
  localparam int RAW_W       = 21;  // sat16 * 25
  localparam int SUM_W       = RAW_W + $clog2(FILTER_TAPS);
  localparam int AVG_Q16     = (65536 * 9999) / (FILTER_TAPS * 10000);
  localparam int AVG_SHIFT   = 8;
  localparam int TGT_SHIFT   = 8;
  localparam int ERR_W       = 25;
  localparam int TE_Q24      = 33554;
  localparam int TE_SHIFT    = 24;
  localparam int OUT_SCALE   = 3744911;  // 57.1428 in Q16
  localparam int COEF_W      = 23;       // signed width for the output scale constant
  localparam int EFF_W       = 33;       // effort clamped to +-2^31
  localparam longint EFF_LIM = 64'sd2147483648;
  localparam int DUTY_LSB    = 40;
  localparam longint MID_Q40 = longint'(PWM_TOP / 2) <<< DUTY_LSB;
  localparam longint TOP_Q40 = longint'(PWM_TOP) <<< DUTY_LSB;

  // Gain reset values
  localparam logic [GAIN_W-1:0] KP_LEFT_RST  = GAIN_W'(741);
  localparam logic [GAIN_W-1:0] KI_LEFT_RST  = GAIN_W'(29622);
  localparam logic [GAIN_W-1:0] KP_RIGHT_RST = GAIN_W'(1062);
  localparam logic [GAIN_W-1:0] KI_RIGHT_RST = GAIN_W'(26477);

  // Register map
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_KP_LEFT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KI_LEFT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KP_RIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KI_RIGHT = 2'd3;

  // Lane sequence steps
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_SUM    = 3'd0;
  localparam logic [STEP_W-1:0] STEP_AVG    = 3'd1;
  localparam logic [STEP_W-1:0] STEP_ERR    = 3'd2;
  localparam logic [STEP_W-1:0] STEP_GAIN   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_TE     = 3'd4;
  localparam logic [STEP_W-1:0] STEP_INT    = 3'd5;
  localparam logic [STEP_W-1:0] STEP_EFFORT = 3'd6;
  localparam logic [STEP_W-1:0] STEP_SCALE  = 3'd7;
  localparam logic [STEP_W-1:0] LAST_STEP   = STEP_SCALE;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic              start;
    logic              calc;
    logic [STEP_W-1:0] step;
    logic              commit;
  } lane_ctl_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              clamped;
    logic [SPD_W-1:0]  speed;
  } lane_res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dwpi_in_if.sv =====
// Input channel: encoder counts and speed setpoints of both wheels.
`timescale 1ns / 1ps
`default_nettype none
interface dwpi_in_if;
  import dwpi_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [CNT_W-1:0] left_count;
  logic signed [CNT_W-1:0] right_count;
  logic signed [TGT_W-1:0] left_target_speed;
  logic signed [TGT_W-1:0] right_target_speed;

  modport source (
    output valid, left_count, right_count, left_target_speed, right_target_speed,
    input  ready
  );
  modport sink (
    input  valid, left_count, right_count, left_target_speed, right_target_speed,
    output ready
  );
endinterface
`default_nettype wire

// ===== hw/rtl/dwpi_out_if.sv =====
// Result channel: duties, clamp flags and filtered speeds of both wheels.
`timescale 1ns / 1ps
`default_nettype none
interface dwpi_out_if;
  import dwpi_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [DUTY_W-1:0]       left_duty;
  logic [DUTY_W-1:0]       right_duty;
  logic                    left_clamped;
  logic                    right_clamped;
  logic signed [SPD_W-1:0] left_speed;
  logic signed [SPD_W-1:0] right_speed;

  modport source (
    output valid, left_duty, right_duty, left_clamped, right_clamped,
           left_speed, right_speed,
    input  ready
  );
  modport sink (
    input  valid, left_duty, right_duty, left_clamped, right_clamped,
           left_speed, right_speed,
    output ready
  );
endinterface
`default_nettype wire

// ===== hw/rtl/dwpi_lane.sv =====
// One wheel of the speed loop: filter, PI update, duty scaling and clamp.
`timescale 1ns / 1ps
`default_nettype none
module dwpi_lane (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dwpi_pkg::lane_ctl_t             ctl,
  input  logic signed [dwpi_pkg::CNT_W-1:0] count,
  input  logic signed [dwpi_pkg::TGT_W-1:0] target,
  input  logic [dwpi_pkg::GAIN_W-1:0]     kp,
  input  logic [dwpi_pkg::GAIN_W-1:0]     ki,
  output dwpi_pkg::lane_res_t             res
);
  import dwpi_pkg::*;

  localparam int MPROD_W = SUM_W + 17;
  localparam int KIE_W   = GAIN_W + 1 + ERR_W;
  localparam int INCP_W  = KIE_W + 17;
  localparam int SSUM_W  = KIE_W + 1;
  localparam int OPROD_W = EFF_W + COEF_W;
  localparam int VAL_W   = OPROD_W + 1;

  localparam logic signed [CNT_W-1:0]   D_HI   = CNT_W'(2**(DIFF_W-1) - 1);
  localparam logic signed [CNT_W-1:0]   D_LO   = -D_HI - CNT_W'(1);
  localparam logic signed [16:0]        AVG_S  = 17'(AVG_Q16);
  localparam logic signed [16:0]        TE_S   = 17'(TE_Q24);
  localparam logic signed [COEF_W-1:0]  SCL_S  = COEF_W'(OUT_SCALE);
  localparam logic signed [MPROD_W-1:0] SPD_HI = MPROD_W'(2**(SPD_W-1) - 1);
  localparam logic signed [MPROD_W-1:0] SPD_LO = -SPD_HI - MPROD_W'(1);
  localparam logic signed [SSUM_W-1:0]  S_HI   = SSUM_W'(EFF_LIM);
  localparam logic signed [SSUM_W-1:0]  S_LO   = -S_HI;
  localparam logic signed [VAL_W-1:0]   V_MID  = VAL_W'(MID_Q40);
  localparam logic signed [VAL_W-1:0]   V_TOP  = VAL_W'(TOP_Q40);

  logic signed [CNT_W-1:0]   cnt_in_r, last_cnt_r;
  logic signed [TGT_W-1:0]   tgt_r;
  logic signed [RAW_W-1:0]   hist_r [HIST_DEPTH];
  logic signed [SUM_W-1:0]   sum_r;
  logic signed [MPROD_W-1:0] mprod_r;
  logic signed [SPD_W-1:0]   speed_r;
  logic signed [ERR_W-1:0]   e_r;
  logic signed [KIE_W-1:0]   kie_r, kpe_r;
  logic signed [INCP_W-1:0]  incp_r;
  logic signed [INT_W-1:0]   newi_r, integ_r;
  logic signed [EFF_W-1:0]   s_r;
  logic signed [OPROD_W-1:0] oprod_r;

  logic signed [CNT_W-1:0]   diff;
  logic signed [CNT_W-1:0]   dsat;
  logic signed [RAW_W-1:0]   dsat_x, raw;
  logic signed [SUM_W-1:0]   sum_nxt;
  logic signed [MPROD_W-1:0] mprod_nxt, sp_full;
  logic signed [SPD_W-1:0]   speed_nxt;
  logic signed [ERR_W-1:0]   e_nxt;
  logic signed [KIE_W-1:0]   kie_nxt, kpe_nxt;
  logic signed [INCP_W-1:0]  incp_nxt;
  logic signed [INT_W:0]     isum;
  logic signed [INT_W-1:0]   newi_nxt;
  logic signed [SSUM_W-1:0]  ssum;
  logic signed [EFF_W-1:0]   s_nxt;
  logic signed [OPROD_W-1:0] oprod_nxt;
  logic signed [VAL_W-1:0]   val;

  // raw speed and tap sum
  always_comb begin
    diff = cnt_in_r - last_cnt_r;
    if (diff > D_HI) begin
      dsat = D_HI;
    end else if (diff < D_LO) begin
      dsat = D_LO;
    end else begin
      dsat = diff;
    end
    dsat_x = RAW_W'(dsat);
    raw = (dsat_x <<< 4) + (dsat_x <<< 3) + dsat_x;
    sum_nxt = SUM_W'(raw);
    for (int i = 0; i < HIST_DEPTH; i++) begin
      sum_nxt = sum_nxt + SUM_W'(hist_r[i]);
    end
  end

  // average, error, gains
  always_comb begin
    mprod_nxt = sum_r * AVG_S;
    sp_full = mprod_r >>> AVG_SHIFT;
    if (sp_full > SPD_HI) begin
      speed_nxt = SPD_W'(SPD_HI);
    end else if (sp_full < SPD_LO) begin
      speed_nxt = SPD_W'(SPD_LO);
    end else begin
      speed_nxt = SPD_W'(sp_full);
    end
    e_nxt = (ERR_W'(tgt_r) <<< TGT_SHIFT) - ERR_W'(speed_nxt);
    kie_nxt = $signed({1'b0, ki}) * e_r;
    kpe_nxt = $signed({1'b0, kp}) * e_r;
    incp_nxt = kie_r * TE_S;
  end

  // integrator, effort, output scaling
  always_comb begin
    isum = (INT_W+1)'(integ_r) + (INT_W+1)'(incp_r >>> TE_SHIFT);
    if (isum[INT_W] != isum[INT_W-1]) begin
      newi_nxt = {isum[INT_W], {(INT_W-1){~isum[INT_W]}}};
    end else begin
      newi_nxt = INT_W'(isum);
    end
    ssum = SSUM_W'(kpe_r) + SSUM_W'(newi_r);
    if (ssum > S_HI) begin
      s_nxt = EFF_W'(S_HI);
    end else if (ssum < S_LO) begin
      s_nxt = EFF_W'(S_LO);
    end else begin
      s_nxt = EFF_W'(ssum);
    end
    oprod_nxt = s_r * SCL_S;
  end

  // duty clamp
  always_comb begin
    val = V_MID - VAL_W'(oprod_r);
    res.speed = speed_r;
    if (val > V_TOP) begin
      res.duty    = DUTY_W'(PWM_TOP);
      res.clamped = 1'b1;
    end else if (val < 0) begin
      res.duty    = '0;
      res.clamped = 1'b1;
    end else begin
      res.duty    = val[DUTY_LSB +: DUTY_W];
      res.clamped = 1'b0;
    end
  end

  // loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_cnt_r <= '0;
      integ_r    <= '0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      if (ctl.calc && ctl.step == STEP_SUM) begin
        last_cnt_r <= cnt_in_r;
        for (int i = 0; i + 1 < HIST_DEPTH; i++) begin
          hist_r[i] <= hist_r[i+1];
        end
        hist_r[HIST_DEPTH-1] <= raw;
      end
      // anti-windup: keep the old integrator when the duty clamps
      if (ctl.commit && !res.clamped) begin
        integ_r <= newi_r;
      end
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      cnt_in_r <= count;
      tgt_r    <= target;
    end
    if (ctl.calc) begin
      case (ctl.step)
        STEP_SUM:    sum_r   <= sum_nxt;
        STEP_AVG:    mprod_r <= mprod_nxt;
        STEP_ERR: begin
          speed_r <= speed_nxt;
          e_r     <= e_nxt;
        end
        STEP_GAIN: begin
          kie_r <= kie_nxt;
          kpe_r <= kpe_nxt;
        end
        STEP_TE:     incp_r  <= incp_nxt;
        STEP_INT:    newi_r  <= newi_nxt;
        STEP_EFFORT: s_r     <= s_nxt;
        STEP_SCALE:  oprod_r <= oprod_nxt;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/dwpi_merge.sv =====
// Output stage: joins both lane results into one registered transfer.
`timescale 1ns / 1ps
`default_nettype none
module dwpi_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  dwpi_pkg::lane_res_t left_res,
  input  dwpi_pkg::lane_res_t right_res,
  output logic                can_load,
  dwpi_out_if.source          out_ch
);
  import dwpi_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  lane_res_t left_r, right_r;

  assign can_load = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      left_r  <= left_res;
      right_r <= right_res;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.left_duty     = left_r.duty;
  assign out_ch.right_duty    = right_r.duty;
  assign out_ch.left_clamped  = left_r.clamped;
  assign out_ch.right_clamped = right_r.clamped;
  assign out_ch.left_speed    = left_r.speed;
  assign out_ch.right_speed   = right_r.speed;

endmodule
`default_nettype wire

// ===== hw/rtl/dual_wheel_pi_speed_loop_core.sv =====
// Sequence: an input transfer captures the item at the transfer edge; the 8 lane
// steps then run, and the merge load follows, waiting while the output still
// holds an unaccepted result; both wheels run in parallel lanes.
// Flow: the lane step sequencer handles one item at a time, the next input is
// taken while a result waits at the output.
// Reset (rst_n low, synchronous): gains to defaults, counts, filter history
// and integrators to zero, output empty.
`timescale 1ns / 1ps
`default_nettype none
module dual_wheel_pi_speed_loop_core (
  input  logic                              clk,
  input  logic                              rst_n,
  dwpi_in_if.sink                           in_ch,
  dwpi_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [dwpi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dwpi_pkg::GAIN_W-1:0]       cfg_wdata
);
  import dwpi_pkg::*;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [GAIN_W-1:0] kp_left_r, ki_left_r, kp_right_r, ki_right_r;
  lane_ctl_t         ctl;
  lane_res_t         left_res, right_res;
  logic              can_load;
  logic              in_xfer;

  assign in_xfer = in_ch.valid && in_ch.ready;

  // gain registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_left_r  <= KP_LEFT_RST;
      ki_left_r  <= KI_LEFT_RST;
      kp_right_r <= KP_RIGHT_RST;
      ki_right_r <= KI_RIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KP_LEFT:  kp_left_r  <= cfg_wdata;
        CFG_KI_LEFT:  ki_left_r  <= cfg_wdata;
        CFG_KP_RIGHT: kp_right_r <= cfg_wdata;
        CFG_KI_RIGHT: ki_right_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        if (step_r == LAST_STEP) begin
          state_nxt = ST_PUSH;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_PUSH: begin
        if (can_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ch.ready = 1'b0;
    ctl.start   = 1'b0;
    ctl.calc    = 1'b0;
    ctl.commit  = 1'b0;
    ctl.step    = step_r;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        ctl.start   = in_ch.valid;
      end
      ST_CALC: ctl.calc = 1'b1;
      ST_PUSH: ctl.commit = can_load;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  dwpi_lane u_lane_left (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .count  (in_ch.left_count),
    .target (in_ch.left_target_speed),
    .kp     (kp_left_r),
    .ki     (ki_left_r),
    .res    (left_res)
  );

  dwpi_lane u_lane_right (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .count  (in_ch.right_count),
    .target (in_ch.right_target_speed),
    .kp     (kp_right_r),
    .ki     (ki_right_r),
    .res    (right_res)
  );

  dwpi_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (ctl.commit),
    .left_res  (left_res),
    .right_res (right_res),
    .can_load  (can_load),
    .out_ch    (out_ch)
  );

  a_accept_starts_calc: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_CALC && step_r == STEP_SUM))
    else $error("input transfer did not start the lane sequence");

  a_result_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(state_r) == ST_PUSH)
    else $error("result appeared without a push step");

  a_left_clamp_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (!out_ch.left_clamped || out_ch.left_duty == '0 ||
                      out_ch.left_duty == DUTY_W'(PWM_TOP)))
    else $error("left clamp flag without duty at a limit");

  a_right_clamp_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (!out_ch.right_clamped || out_ch.right_duty == '0 ||
                      out_ch.right_duty == DUTY_W'(PWM_TOP)))
    else $error("right clamp flag without duty at a limit");

endmodule
`default_nettype wire
